// ----- rtl/core/aob_pkg.sv -----
package aob_pkg;

   // Field and datapath widths
   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned NUM_CHAN    = 3;
   localparam int unsigned NUM_W       = 24;  // 255 * 65025 fits in 24 bits
   localparam int unsigned DIV_W       = 16;  // k <= 65025
   localparam int unsigned QUO_BITS    = 8;   // one quotient bit per cell
   localparam int unsigned PREP_STAGES = 2;
   localparam int unsigned LATENCY     = PREP_STAGES + QUO_BITS + 1;

   localparam logic [CHAN_W-1:0] FULL_OPACITY = 8'hFF;
   localparam logic [CHAN_W-1:0] ZERO_OPACITY = 8'h00;

   // floor(x / 255) == (x * 32897) >> 23 for every 16-bit x
   localparam int unsigned       RECIP_W     = 17;
   localparam logic [RECIP_W-1:0] RECIP_255  = 17'd32897;
   localparam int unsigned       RECIP_SHIFT = 23;
   localparam int unsigned       PROD_W      = DIV_W + RECIP_W;

   // Lane order inside the divider
   localparam int unsigned LANE_RED   = 0;
   localparam int unsigned LANE_GREEN = 1;
   localparam int unsigned LANE_BLUE  = 2;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } aob_pixel_type;

   // Payload handed from cell to cell
   typedef struct packed {
      logic [NUM_CHAN-1:0][NUM_W-1:0]    rem;
      logic [NUM_CHAN-1:0][QUO_BITS-1:0] quo;
      logic [DIV_W-1:0]                  divisor;
      logic                              bypass;
      aob_pixel_type                     pix;   // bypass pixel, or blended alpha
   } aob_div_type;

endpackage

// ----- rtl/core/alpha_over_blend.sv -----
// Non-premultiplied RGBA8 "over" compositor. An item is taken on every clock
// at which start is high; busy is always low, so a new pixel may enter every
// cycle. Each result appears on the rsp_ ports for one cycle with rsp_valid
// high, after its item has passed the weight and numerator registers, 8
// divider cells that each settle one quotient bit for all three color
// channels, and one output register. Results come out in input order
// and cannot be held off; the receiver must take each one when it appears.
module alpha_over_blend
   import aob_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CHAN_W-1:0] req_back_red,
   input  logic [CHAN_W-1:0] req_back_green,
   input  logic [CHAN_W-1:0] req_back_blue,
   input  logic [CHAN_W-1:0] req_back_alpha,
   input  logic [CHAN_W-1:0] req_front_red,
   input  logic [CHAN_W-1:0] req_front_green,
   input  logic [CHAN_W-1:0] req_front_blue,
   input  logic [CHAN_W-1:0] req_front_alpha,
   output logic              rsp_valid,
   output logic [CHAN_W-1:0] rsp_out_red,
   output logic [CHAN_W-1:0] rsp_out_green,
   output logic [CHAN_W-1:0] rsp_out_blue,
   output logic [CHAN_W-1:0] rsp_out_alpha
);

   aob_pixel_type back_pix;
   aob_pixel_type front_pix;
   logic          accept;

   // Fully pipelined: never busy
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign back_pix  = '{red: req_back_red, green: req_back_green,
                        blue: req_back_blue, alpha: req_back_alpha};
   assign front_pix = '{red: req_front_red, green: req_front_green,
                        blue: req_front_blue, alpha: req_front_alpha};

   // Chain of divider cells, MSB of the quotient first
   logic        cell_valid [QUO_BITS+1];
   aob_div_type cell_data  [QUO_BITS+1];

   aob_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .back      (back_pix),
      .front     (front_pix),
      .out_valid (cell_valid[0]),
      .out_data  (cell_data[0])
   );

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_cell
      aob_div_cell #(
         .BIT (QUO_BITS - 1 - g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[g]),
         .in_data   (cell_data[g]),
         .out_valid (cell_valid[g+1]),
         .out_data  (cell_data[g+1])
      );
   end

   // Output register: quotients or the bypass pixel
   logic          rsp_valid_ff, rsp_valid_in;
   aob_pixel_type rsp_pix_ff,   rsp_pix_in;
   aob_div_type   last;

   assign last = cell_data[QUO_BITS];

   always_comb begin
      rsp_valid_in = cell_valid[QUO_BITS];
      if (last.bypass) begin
         rsp_pix_in = last.pix;
      end else begin
         rsp_pix_in.red   = last.quo[LANE_RED];
         rsp_pix_in.green = last.quo[LANE_GREEN];
         rsp_pix_in.blue  = last.quo[LANE_BLUE];
         rsp_pix_in.alpha = last.pix.alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pix_ff <= rsp_pix_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_pix_ff.red;
   assign rsp_out_green = rsp_pix_ff.green;
   assign rsp_out_blue  = rsp_pix_ff.blue;
   assign rsp_out_alpha = rsp_pix_ff.alpha;

   // Every taken item yields a result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("result missing after pipeline latency");
   // Opaque front gives full alpha
   a_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_front_alpha, LATENCY) == FULL_OPACITY
      |-> rsp_out_alpha == FULL_OPACITY)
      else $error("opaque front did not give full alpha");
   // Transparent front passes the back alpha through
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_front_alpha, LATENCY) == ZERO_OPACITY
      |-> rsp_out_alpha == $past(req_back_alpha, LATENCY))
      else $error("transparent front changed back alpha");

endmodule

// ----- rtl/core/aob_prep.sv -----
module aob_prep
   import aob_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  aob_pixel_type back,
   input  aob_pixel_type front,
   output logic          out_valid,
   output aob_div_type   out_data
);

   // Stage 1: alpha weights, bypass decision
   logic          s1_valid_ff,  s1_valid_in;
   aob_pixel_type s1_back_ff,   s1_back_in;
   aob_pixel_type s1_front_ff,  s1_front_in;
   logic [DIV_W-1:0] s1_wb_ff,  s1_wb_in;
   logic [DIV_W-1:0] s1_wf_ff,  s1_wf_in;
   logic          s1_bypass_ff, s1_bypass_in;
   aob_pixel_type s1_pix_ff,    s1_pix_in;

   always_comb begin
      s1_valid_in  = in_valid;
      s1_back_in   = back;
      s1_front_in  = front;
      s1_wb_in     = DIV_W'(back.alpha) * DIV_W'(FULL_OPACITY - front.alpha);
      s1_wf_in     = DIV_W'(front.alpha) * DIV_W'(FULL_OPACITY);
      s1_bypass_in = (front.alpha == ZERO_OPACITY) || (front.alpha == FULL_OPACITY);
      if (front.alpha == ZERO_OPACITY) begin
         s1_pix_in = back;
      end else begin
         s1_pix_in       = front;
         s1_pix_in.alpha = FULL_OPACITY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_back_ff   <= s1_back_in;
      s1_front_ff  <= s1_front_in;
      s1_wb_ff     <= s1_wb_in;
      s1_wf_ff     <= s1_wf_in;
      s1_bypass_ff <= s1_bypass_in;
      s1_pix_ff    <= s1_pix_in;
   end

   // Stage 2: numerators, divisor k and blended alpha k / 255
   logic             s2_valid_ff, s2_valid_in;
   aob_div_type      s2_data_ff,  s2_data_in;
   logic [DIV_W-1:0] k_sum;
   logic [PROD_W-1:0] alpha_prod;

   always_comb begin
      k_sum      = s1_wb_ff + s1_wf_ff;
      alpha_prod = PROD_W'(k_sum) * PROD_W'(RECIP_255);
      s2_valid_in = s1_valid_ff;
      s2_data_in.rem[LANE_RED]   = NUM_W'(s1_back_ff.red)    * NUM_W'(s1_wb_ff)
                                 + NUM_W'(s1_front_ff.red)   * NUM_W'(s1_wf_ff);
      s2_data_in.rem[LANE_GREEN] = NUM_W'(s1_back_ff.green)  * NUM_W'(s1_wb_ff)
                                 + NUM_W'(s1_front_ff.green) * NUM_W'(s1_wf_ff);
      s2_data_in.rem[LANE_BLUE]  = NUM_W'(s1_back_ff.blue)   * NUM_W'(s1_wb_ff)
                                 + NUM_W'(s1_front_ff.blue)  * NUM_W'(s1_wf_ff);
      s2_data_in.quo     = '0;
      s2_data_in.divisor = k_sum;
      s2_data_in.bypass  = s1_bypass_ff;
      s2_data_in.pix     = s1_pix_ff;
      if (!s1_bypass_ff) begin
         s2_data_in.pix.alpha = alpha_prod[RECIP_SHIFT +: CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_data_ff <= s2_data_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// ----- rtl/core/aob_div_cell.sv -----
module aob_div_cell
   import aob_pkg::*;
#(
   parameter int unsigned BIT = 0
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  aob_div_type in_data,
   output logic        out_valid,
   output aob_div_type out_data
);

   logic        valid_ff, valid_in;
   aob_div_type data_ff,  data_in;
   logic [NUM_W-1:0] in_d;
   logic [NUM_W-1:0] out_d;
   logic [NUM_CHAN-1:0][NUM_W:0] diff;

   // One restoring-division step per lane: try k << BIT
   always_comb begin
      in_d     = NUM_W'(in_data.divisor) << BIT;
      valid_in = in_valid;
      data_in  = in_data;
      for (int c = 0; c < NUM_CHAN; c++) begin
         diff[c] = {1'b0, in_data.rem[c]} - {1'b0, in_d};
         data_in.quo[c] = {in_data.quo[c][QUO_BITS-2:0], ~diff[c][NUM_W]};
         if (!diff[c][NUM_W]) begin
            data_in.rem[c] = diff[c][NUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_d     = NUM_W'(data_ff.divisor) << BIT;

   // After this step every remainder of a non-bypass item is below the divisor weight of this bit
   a_rem_red: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.bypass |-> out_data.rem[LANE_RED] < out_d)
      else $error("red remainder not reduced");
   a_rem_green: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.bypass |-> out_data.rem[LANE_GREEN] < out_d)
      else $error("green remainder not reduced");
   a_rem_blue: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.bypass |-> out_data.rem[LANE_BLUE] < out_d)
      else $error("blue remainder not reduced");

endmodule

// ----- test/testbench.sv -----
module testbench;
   import aob_pkg::*;

   localparam int unsigned RANDOM_PIXELS = 1300;
   localparam int unsigned STALL_LIMIT   = 1000;

   typedef struct {
      aob_pixel_type back;
      aob_pixel_type front;
      int unsigned   gap;
   } pixel_job_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   aob_pixel_type drv_back  = '0;
   aob_pixel_type drv_front = '0;
   logic rsp_valid;
   aob_pixel_type rsp_pixel;

   pixel_job_type pixel_jobs[$];
   aob_pixel_type blend_due[$];
   logic          taken = 1'b0;
   int unsigned   idle_left = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   stall_cycles = 0;

   alpha_over_blend u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_back_red    (drv_back.red),
      .req_back_green  (drv_back.green),
      .req_back_blue   (drv_back.blue),
      .req_back_alpha  (drv_back.alpha),
      .req_front_red   (drv_front.red),
      .req_front_green (drv_front.green),
      .req_front_blue  (drv_front.blue),
      .req_front_alpha (drv_front.alpha),
      .rsp_valid       (rsp_valid),
      .rsp_out_red     (rsp_pixel.red),
      .rsp_out_green   (rsp_pixel.green),
      .rsp_out_blue    (rsp_pixel.blue),
      .rsp_out_alpha   (rsp_pixel.alpha)
   );

   // 20 unit clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // One color channel of the partial-alpha case, truncating division by k
   function automatic logic [CHAN_W-1:0] mix_channel(int unsigned back, int unsigned front,
                                                      int unsigned ba, int unsigned fa,
                                                      int unsigned k);
      int unsigned num;
      num = back * ba * (255 - fa) + front * fa * 255;
      return CHAN_W'(num / k);
   endfunction

   // Non-premultiplied "over" of front onto back
   function automatic aob_pixel_type blend_over(aob_pixel_type back, aob_pixel_type front);
      aob_pixel_type mix;
      int unsigned   ba;
      int unsigned   fa;
      int unsigned   k;
      ba = 32'(back.alpha);
      fa = 32'(front.alpha);
      if (front.alpha == ZERO_OPACITY) begin
         mix = back;
      end else if (front.alpha == FULL_OPACITY) begin
         mix = front;
         mix.alpha = FULL_OPACITY;
      end else begin
         k = 255 * (ba + fa) - ba * fa;
         mix.red   = mix_channel(32'(back.red),   32'(front.red),   ba, fa, k);
         mix.green = mix_channel(32'(back.green), 32'(front.green), ba, fa, k);
         mix.blue  = mix_channel(32'(back.blue),  32'(front.blue),  ba, fa, k);
         mix.alpha = CHAN_W'(k / 255);
      end
      return mix;
   endfunction

   task automatic report(string what);
      mismatch_count++;
      $display("mismatch @%0t: %s", $time, what);
   endtask

   task automatic add_pixel(aob_pixel_type back, aob_pixel_type front, int unsigned gap);
      pixel_job_type job;
      job.back  = back;
      job.front = front;
      job.gap   = gap;
      pixel_jobs.push_back(job);
   endtask

   // Byte value leaning toward the ends of the range
   function automatic logic [CHAN_W-1:0] pick_level();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd1;
         3:       return 8'd254;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   function automatic aob_pixel_type pick_pixel();
      aob_pixel_type pix;
      pix.red   = ($urandom_range(0, 3) == 0) ? pick_level() : CHAN_W'($urandom);
      pix.green = ($urandom_range(0, 3) == 0) ? pick_level() : CHAN_W'($urandom);
      pix.blue  = ($urandom_range(0, 3) == 0) ? pick_level() : CHAN_W'($urandom);
      pix.alpha = pick_level();
      return pix;
   endfunction

   // Driver: present the next item at the falling edge, hold it until taken
   always @(negedge clock) begin : drive_pixels
      pixel_job_type job;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (idle_left > 0) begin
            start <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (pixel_jobs.size() > 0) begin
            job = pixel_jobs.pop_front();
            drv_back  <= job.back;
            drv_front <= job.front;
            idle_left <= job.gap;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predict on acceptance, check each strobed result in order
   always @(posedge clock) begin : watch_pixels
      aob_pixel_type want;
      taken <= !reset && start && !busy;
      if (!reset) begin
         if (start && !busy) begin
            blend_due.push_back(blend_over(drv_back, drv_front));
         end
         if (rsp_valid) begin
            if (blend_due.size() == 0) begin
               report($sformatf("unexpected result %h", rsp_pixel));
            end else begin
               want = blend_due.pop_front();
               if (rsp_pixel !== want)
                  report($sformatf("rgba got %h/%h/%h/%h expected %h/%h/%h/%h",
                                   rsp_pixel.red, rsp_pixel.green, rsp_pixel.blue,
                                   rsp_pixel.alpha, want.red, want.green, want.blue,
                                   want.alpha));
            end
         end
         // watchdog on cycles with no traffic either way
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      aob_pixel_type back;
      aob_pixel_type front;
      int unsigned   idle_style;
      int unsigned   gap;

      // Directed: transparent front passes back through
      add_pixel('{8'd12, 8'd200, 8'd255, 8'd77}, '{8'd255, 8'd255, 8'd255, 8'd0}, 0);
      add_pixel('{8'd255, 8'd0, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd0, 8'd0}, 0);
      add_pixel('{8'd0, 8'd0, 8'd0, 8'd255}, '{8'd9, 8'd9, 8'd9, 8'd0}, 3);
      // opaque front replaces back
      add_pixel('{8'd10, 8'd20, 8'd30, 8'd40}, '{8'd255, 8'd0, 8'd128, 8'd255}, 0);
      add_pixel('{8'd255, 8'd255, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd0, 8'd255}, 1);
      // partial front at its extremes and over extreme back alphas; then mid, transparent and opaque fronts
      add_pixel('{8'd255, 8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd0, 8'd1}, 0);
      add_pixel('{8'd0, 8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd255, 8'd254}, 0);
      add_pixel('{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255, 8'd1}, 2);
      add_pixel('{8'd255, 8'd255, 8'd255, 8'd0}, '{8'd0, 8'd128, 8'd255, 8'd254}, 0);
      add_pixel('{8'd255, 8'd255, 8'd255, 8'd1}, '{8'd255, 8'd255, 8'd255, 8'd1}, 0);
      add_pixel('{8'd255, 8'd255, 8'd255, 8'd254}, '{8'd255, 8'd255, 8'd255, 8'd254}, 10);
      add_pixel('{8'd0, 8'd255, 8'd0, 8'd128}, '{8'd255, 8'd0, 8'd255, 8'd128}, 0);
      add_pixel('{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0, 8'd0}, 0);
      add_pixel('{8'd255, 8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255, 8'd255}, 0);
      add_pixel('{8'd170, 8'd85, 8'd51, 8'd255}, '{8'd85, 8'd170, 8'd204, 8'd127}, 5);
      add_pixel('{8'd1, 8'd254, 8'd1, 8'd1}, '{8'd254, 8'd1, 8'd254, 8'd255}, 0);

      // Random pixels; idling style changes every 100 items, sometimes none
      idle_style = 0;
      for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
         if (n % 100 == 0)
            idle_style = $urandom_range(0, 2);
         back  = pick_pixel();
         front = pick_pixel();
         case (idle_style)
            0:       gap = 0;
            1:       gap = $urandom_range(0, 10);
            default: gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) : 0;
         endcase
         add_pixel(back, front, gap);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: all items in, every expected result back, then settle
      while (pixel_jobs.size() > 0 || start || blend_due.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      if (blend_due.size() > 0)
         report($sformatf("%0d results never arrived", blend_due.size()));
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
